/* rtl/dense_layer_sigmoid_neuron_unit_macros.svh */
// ----------------------------------------------------------------------------
// dense layer neuron assertion macros
// Concurrent assertion wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef DENSE_LAYER_SIGMOID_NEURON_UNIT_MACROS_SVH
`define DENSE_LAYER_SIGMOID_NEURON_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define DLSN_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dlsn assertion failed");
// next-cycle implication
`define DLSN_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dlsn assertion failed");
`else
`define DLSN_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define DLSN_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/dlsn_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlsn_pkg
// Shared types, constants and the sigmoid table generator.
// ----------------------------------------------------------------------------
package dlsn_pkg;

    localparam int DEF_MAX_INPUTS = 64;
    localparam int DEF_SIG_DEPTH  = 256;
    localparam int QUEUE_DEPTH    = 4;
    localparam int ACC_W          = 48;
    localparam int OUT_COUNT_MAX  = 64;
    localparam int CFG_INDEX_W    = 2;
    localparam int CFG_DATA_W     = 7;

    localparam logic [CFG_INDEX_W-1:0] CFG_INPUT_COUNT  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_OUTPUT_COUNT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ACT_MODE     = 2'd2;

    localparam logic KIND_LOAD   = 1'b0;
    localparam logic KIND_WEIGHT = 1'b1;

    localparam logic [12:0] Q12_ONE  = 13'd4096;
    localparam logic [63:0] Q30_ONE  = 64'd1 << 30;

    typedef struct packed {
        logic               kind;
        logic [6:0]         act_index;
        logic signed [15:0] act_value;
        logic signed [15:0] weight;
    } t_in_item;

    typedef struct packed {
        logic [6:0]         neuron_index;
        logic signed [15:0] pre_activation;
        logic signed [15:0] activation;
        logic [12:0]        derivative;
    } t_out_item;

    // one multiply-accumulate step handed from front to back
    typedef struct packed {
        logic signed [15:0] weight;
        logic signed [15:0] act;
        logic               bias;
        logic               last;
    } t_term;

    // finished weighted sum handed to the activation sequencer
    typedef struct packed {
        logic                    valid;
        logic signed [ACC_W-1:0] sum;
    } t_sum_hand;

    // shift-subtract divide, elaboration only
    function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] q;
        logic [64:0] r;
        int          b;
        q = '0;
        r = '0;
        for (b = 63; b >= 0; b--) begin
            r = {r[63:0], n[b]};
            if (r >= {1'b0, d}) begin
                r    = r - {1'b0, d};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // exp(-f) in q30 for 0 <= f <= 1.0, truncated taylor series
    function automatic logic [63:0] exp_neg_q30(input logic [63:0] f);
        logic signed [63:0] sum;
        logic [63:0]        term;
        int                 k;
        sum  = $signed(Q30_ONE);
        term = Q30_ONE;
        for (k = 1; k <= 24; k++) begin
            term = udiv64((term * f) >> 30, 64'(k));
            if (k[0]) begin
                sum = sum - $signed(term);
            end else begin
                sum = sum + $signed(term);
            end
        end
        if (sum < 0) begin
            sum = '0;
        end
        return $unsigned(sum);
    endfunction

    // sigmoid table entry i of depth+1, sampled over [-8,8], q1.12
    function automatic logic [12:0] sig_entry(input int unsigned i, input int unsigned depth);
        logic [63:0] d;
        logic [63:0] num;
        logic [63:0] mid;
        logic [63:0] a;
        logic [63:0] u;
        logic [63:0] n;
        logic [63:0] e;
        logic [63:0] e1;
        logic [63:0] s;
        logic [63:0] v;
        logic        neg;
        int unsigned j;
        d   = 64'(depth);
        num = 64'd16 * 64'(i);
        mid = 64'd8 * d;
        neg = num < mid;
        a   = neg ? mid - num : num - mid;
        u   = udiv64(a << 30, d);
        n   = u >> 30;
        e1  = exp_neg_q30(Q30_ONE);
        e   = exp_neg_q30(u & (Q30_ONE - 64'd1));
        for (j = 0; 64'(j) < n; j++) begin
            e = (e * e1 + (Q30_ONE >> 1)) >> 30;
        end
        s = udiv64(64'd1 << 60, Q30_ONE + e);
        v = (s * 64'd4096 + (Q30_ONE >> 1)) >> 30;
        if (v > 64'd4096) begin
            v = 64'd4096;
        end
        return neg ? 13'(64'd4096 - v) : 13'(v);
    endfunction

endpackage

/* rtl/dlsn_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlsn_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dlsn_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/dlsn_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlsn_front
// Accepts transactions, writes loads to the activation store, tags weights
// as bias or last term and fetches the matching stored activation.
// ----------------------------------------------------------------------------
module dlsn_front #(
    parameter int MAX_INPUTS = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  dlsn_pkg::t_in_item i_item,
    output logic              o_full,
    input  logic [6:0]        i_input_count,
    output logic              o_term_push,
    output dlsn_pkg::t_term   o_term,
    input  logic              i_queue_full
);
    import dlsn_pkg::*;

    localparam int AW = $clog2(MAX_INPUTS);
    localparam int TW = $clog2(MAX_INPUTS + 1);

    logic [TW-1:0]      r_term_cnt;
    logic [TW-1:0]      n_term_cnt;
    logic               r_f1_valid;
    logic               n_f1_valid;
    logic signed [15:0] r_f1_weight;
    logic               r_f1_bias;
    logic               r_f1_last;

    logic        w_accept;
    logic        w_is_weight;
    logic        w_is_bias;
    logic        w_last;
    logic        w_load_ok;
    logic [31:0] w_n_in;
    logic [31:0] w_slot_m1;
    logic [31:0] w_rd_idx;
    logic [15:0] w_rdata;

    assign o_full      = r_f1_valid && i_queue_full;
    assign w_accept    = i_push && !o_full;
    assign w_is_weight = i_item.kind == KIND_WEIGHT;
    assign w_is_bias   = r_term_cnt == '0;
    assign w_slot_m1   = 32'(i_item.act_index) - 32'd1;
    assign w_rd_idx    = 32'(r_term_cnt) - 32'd1;
    assign w_load_ok   = (i_item.kind == KIND_LOAD) && (i_item.act_index != 7'd0)
                         && (32'(i_item.act_index) <= 32'(MAX_INPUTS));

    always_comb begin
        w_n_in = 32'(i_input_count);
        if (w_n_in == 32'd0) begin
            w_n_in = 32'd1;
        end else if (w_n_in > 32'(MAX_INPUTS)) begin
            w_n_in = 32'(MAX_INPUTS);
        end
    end

    // also covers a count lowered while a neuron is in flight
    assign w_last = !w_is_bias && (32'(r_term_cnt) >= w_n_in);

    always_comb begin
        n_term_cnt = r_term_cnt;
        if (w_accept && w_is_weight) begin
            if (w_last) begin
                n_term_cnt = '0;
            end else begin
                n_term_cnt = r_term_cnt + TW'(1);
            end
        end
    end

    always_comb begin
        n_f1_valid = r_f1_valid;
        if (w_accept && w_is_weight) begin
            n_f1_valid = 1'b1;
        end else if (r_f1_valid && !i_queue_full) begin
            n_f1_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_term_cnt <= '0;
            r_f1_valid <= 1'b0;
        end else begin
            r_term_cnt <= n_term_cnt;
            r_f1_valid <= n_f1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_is_weight) begin
            r_f1_weight <= i_item.weight;
            r_f1_bias   <= w_is_bias;
            r_f1_last   <= w_last;
        end
    end

    dlsn_ram #(
        .WIDTH (16),
        .DEPTH (MAX_INPUTS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_accept && w_load_ok),
        .i_waddr (w_slot_m1[AW-1:0]),
        .i_wdata (i_item.act_value),
        .i_re    (w_accept && w_is_weight && !w_is_bias),
        .i_raddr (w_rd_idx[AW-1:0]),
        .o_rdata (w_rdata)
    );

    assign o_term_push   = r_f1_valid && !i_queue_full;
    assign o_term.weight = r_f1_weight;
    assign o_term.act    = $signed(w_rdata);
    assign o_term.bias   = r_f1_bias;
    assign o_term.last   = r_f1_last;

endmodule

/* rtl/dlsn_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlsn_fifo
// Short queue of multiply-accumulate steps between front and back.
// ----------------------------------------------------------------------------
`include "dense_layer_sigmoid_neuron_unit_macros.svh"
module dlsn_fifo #(
    parameter int DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  dlsn_pkg::t_term i_data,
    output logic            o_full,
    input  logic            i_pop,
    output dlsn_pkg::t_term o_data,
    output logic            o_empty
);
    import dlsn_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_term         r_mem [0:DEPTH-1];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic [PW-1:0] n_wr_ptr;
    logic [PW-1:0] n_rd_ptr;
    logic [CW-1:0] n_count;
    logic          w_do_push;
    logic          w_do_pop;

    assign o_full    = r_count == CW'(DEPTH);
    assign o_empty   = r_count == '0;
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;
    assign o_data    = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_do_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
        end
        if (w_do_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
        end
        if (w_do_push && !w_do_pop) begin
            n_count = r_count + CW'(1);
        end else if (!w_do_push && w_do_pop) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    `DLSN_ASSERT_IMP(a_push_not_full, i_clk, i_rst_n, i_push, !o_full)
    `DLSN_ASSERT_IMP(a_pop_not_empty, i_clk, i_rst_n, i_pop, !o_empty)

endmodule

/* rtl/dlsn_mac.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlsn_mac
// Multiply stage and 48-bit accumulator; hands each finished sum onward.
// ----------------------------------------------------------------------------
`include "dense_layer_sigmoid_neuron_unit_macros.svh"
module dlsn_mac (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_term_valid,
    input  dlsn_pkg::t_term     i_term,
    output logic                o_term_pop,
    output dlsn_pkg::t_sum_hand o_sum,
    input  logic                i_sum_ready
);
    import dlsn_pkg::*;

    logic                    r_b1_valid;
    logic                    n_b1_valid;
    logic signed [31:0]      r_b1_prod;
    logic                    r_b1_bias;
    logic                    r_b1_last;
    logic signed [ACC_W-1:0] r_acc;

    logic                    w_b1_move;
    logic                    w_b1_load;
    logic signed [31:0]      w_prod;
    logic signed [ACC_W-1:0] w_sum;

    assign w_b1_move  = r_b1_valid && (!r_b1_last || i_sum_ready);
    assign w_b1_load  = !r_b1_valid || w_b1_move;
    assign o_term_pop = i_term_valid && w_b1_load;

    // bias is scaled by an implicit 1.0
    assign w_prod = i_term.bias ? ($signed(32'(i_term.weight)) <<< 12)
                                : (32'(i_term.weight) * 32'(i_term.act));

    assign w_sum = (r_b1_bias ? '0 : r_acc) + ACC_W'(r_b1_prod);

    assign o_sum.valid = r_b1_valid && r_b1_last;
    assign o_sum.sum   = w_sum;

    always_comb begin
        n_b1_valid = r_b1_valid;
        if (w_b1_load) begin
            n_b1_valid = i_term_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_valid <= 1'b0;
            r_acc      <= '0;
        end else begin
            r_b1_valid <= n_b1_valid;
            if (w_b1_move) begin
                r_acc <= r_b1_last ? '0 : w_sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_term_pop) begin
            r_b1_prod <= w_prod;
            r_b1_bias <= i_term.bias;
            r_b1_last <= i_term.last;
        end
    end

    `DLSN_ASSERT_NXT(a_last_held, i_clk, i_rst_n, r_b1_valid && r_b1_last && !i_sum_ready,
                     r_b1_valid && r_b1_last)

endmodule

/* rtl/dlsn_act.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlsn_act
// Per-neuron sequencer: round and saturate, sigmoid lookup with linear
// interpolation and derivative (skipped in identity mode), and the result register.
// ----------------------------------------------------------------------------
`include "dense_layer_sigmoid_neuron_unit_macros.svh"
module dlsn_act #(
    parameter int SIG_DEPTH = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  dlsn_pkg::t_sum_hand i_sum,
    output logic                o_sum_ready,
    input  logic                i_act_mode,
    input  logic [6:0]          i_output_count,
    output logic                o_empty,
    input  logic                i_pop,
    output dlsn_pkg::t_out_item o_item
);
    import dlsn_pkg::*;

    localparam int TIW = $clog2(SIG_DEPTH + 1);
    localparam int PW  = 16 + TIW;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ROUND,
        ST_POS,
        ST_LOOKUP,
        ST_INTERP_MUL,
        ST_INTERP_ADD,
        ST_DERIV_MUL,
        ST_DERIV_ADD,
        ST_DONE
    } t_state;

    t_state                  r_state;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [15:0]      r_p;
    logic [TIW-1:0]          r_seg;
    logic [15:0]             r_rem;
    logic [12:0]             r_t0;
    logic [12:0]             r_t1;
    logic signed [31:0]      r_iprod;
    logic signed [15:0]      r_y;
    logic [25:0]             r_dprod;
    logic [12:0]             r_d;
    logic [6:0]              r_nidx;
    logic [5:0]              r_ncnt;

    logic [12:0]             w_tab [0:SIG_DEPTH];
    logic signed [ACC_W-1:0] w_rnd;
    logic signed [15:0]      w_p;
    logic [PW-1:0]           w_pos;
    logic signed [13:0]      w_diff;
    logic signed [31:0]      w_interp;
    logic [12:0]             w_y13;
    logic [6:0]              w_n_out;
    logic [6:0]              w_ncnt_inc;

    for (genvar gi = 0; gi <= SIG_DEPTH; gi++) begin : g_tab
        localparam logic [12:0] ENTRY = sig_entry(gi, SIG_DEPTH);
        assign w_tab[gi] = ENTRY;
    end

    // round half up from q24.24 to q4.12, then saturate
    assign w_rnd = (r_acc + 48'sd2048) >>> 12;
    always_comb begin
        if (w_rnd > 48'sd32767) begin
            w_p = 16'sh7fff;
        end else if (w_rnd < -48'sd32768) begin
            w_p = -16'sh8000;
        end else begin
            w_p = w_rnd[15:0];
        end
    end

    assign w_pos    = PW'({~r_p[15], r_p[14:0]}) * PW'(SIG_DEPTH);
    assign w_diff   = $signed({1'b0, r_t1}) - $signed({1'b0, r_t0});
    assign w_interp = $signed(32'(r_t0)) + ((r_iprod + 32'sd32768) >>> 16);
    assign w_y13    = r_y[12:0];

    always_comb begin
        w_n_out = i_output_count;
        if (w_n_out == 7'd0) begin
            w_n_out = 7'd1;
        end else if (w_n_out > 7'(OUT_COUNT_MAX)) begin
            w_n_out = 7'(OUT_COUNT_MAX);
        end
    end
    assign w_ncnt_inc = 7'(r_ncnt) + 7'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ncnt  <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_sum.valid) begin
                        r_acc   <= i_sum.sum;
                        r_nidx  <= w_ncnt_inc;
                        r_ncnt  <= (w_ncnt_inc >= w_n_out) ? '0 : w_ncnt_inc[5:0];
                        r_state <= ST_ROUND;
                    end
                end
                ST_ROUND: begin
                    r_p     <= w_p;
                    r_state <= ST_POS;
                end
                ST_POS: begin
                    if (i_act_mode) begin
                        r_y     <= r_p;
                        r_d     <= Q12_ONE;
                        r_state <= ST_DONE;
                    end else begin
                        r_seg   <= w_pos[PW-1:16];
                        r_rem   <= w_pos[15:0];
                        r_state <= ST_LOOKUP;
                    end
                end
                ST_LOOKUP: begin
                    r_t0    <= w_tab[r_seg];
                    r_t1    <= w_tab[r_seg + TIW'(1)];
                    r_state <= ST_INTERP_MUL;
                end
                ST_INTERP_MUL: begin
                    r_iprod <= 32'(w_diff) * $signed({16'd0, r_rem});
                    r_state <= ST_INTERP_ADD;
                end
                ST_INTERP_ADD: begin
                    r_y     <= w_interp[15:0];
                    r_state <= ST_DERIV_MUL;
                end
                ST_DERIV_MUL: begin
                    r_dprod <= 26'(w_y13) * 26'(Q12_ONE - w_y13);
                    r_state <= ST_DERIV_ADD;
                end
                ST_DERIV_ADD: begin
                    r_d     <= 13'((r_dprod + 26'd2048) >> 12);
                    r_state <= ST_DONE;
                end
                ST_DONE: begin
                    if (i_pop) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_sum_ready           = r_state == ST_IDLE;
    assign o_empty               = r_state != ST_DONE;
    assign o_item.neuron_index   = r_nidx;
    assign o_item.pre_activation = r_p;
    assign o_item.activation     = r_y;
    assign o_item.derivative     = r_d;

    `DLSN_ASSERT_NXT(a_capture_starts, i_clk, i_rst_n, o_sum_ready && i_sum.valid,
                     r_state == ST_ROUND)
    `DLSN_ASSERT_IMP(a_deriv_range, i_clk, i_rst_n, !o_empty, o_item.derivative <= Q12_ONE)

endmodule

/* rtl/dense_layer_sigmoid_neuron_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dense_layer_sigmoid_neuron_unit
// Fully connected layer with sigmoid activation, one neuron at a time, Q4.12.
// ----------------------------------------------------------------------------
// Load transactions write the activation store. Weight transactions stream
// one per cycle, unless full holds them back, through the front stage, a
// four-entry queue and a single 16x16 multiply-accumulate; a neuron with N
// inputs takes N+1 weight transactions, the first being the bias. Each
// finished neuron then runs through the activation sequencer (round, table
// lookup, interpolation, derivative) that holds one result until it is
// popped; the accumulator keeps working on the next neuron meanwhile, and
// is held back only while a finished sum waits for the sequencer to go idle.
// Identity mode skips the lookup, interpolation and derivative steps.
module dense_layer_sigmoid_neuron_unit #(
    parameter int MAX_INPUTS          = dlsn_pkg::DEF_MAX_INPUTS,
    parameter int SIGMOID_TABLE_DEPTH = dlsn_pkg::DEF_SIG_DEPTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                push,
    input  dlsn_pkg::t_in_item                  i_in_item,
    output logic                                full,
    output logic                                empty,
    input  logic                                pop,
    output dlsn_pkg::t_out_item                 o_out_item,
    input  logic                                i_cfg_we,
    input  logic [dlsn_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [dlsn_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import dlsn_pkg::*;

    logic [6:0] r_input_count;
    logic [6:0] r_output_count;
    logic       r_act_mode;

    logic       w_term_push;
    t_term      w_term_in;
    logic       w_queue_full;
    logic       w_term_pop;
    t_term      w_term_out;
    logic       w_queue_empty;
    t_sum_hand  w_sum;
    logic       w_sum_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_input_count  <= 7'd1;
            r_output_count <= 7'd1;
            r_act_mode     <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_INPUT_COUNT:  r_input_count  <= i_cfg_data;
                CFG_OUTPUT_COUNT: r_output_count <= i_cfg_data;
                CFG_ACT_MODE:     r_act_mode     <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    dlsn_front #(
        .MAX_INPUTS (MAX_INPUTS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .i_item        (i_in_item),
        .o_full        (full),
        .i_input_count (r_input_count),
        .o_term_push   (w_term_push),
        .o_term        (w_term_in),
        .i_queue_full  (w_queue_full)
    );

    dlsn_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_term_push),
        .i_data  (w_term_in),
        .o_full  (w_queue_full),
        .i_pop   (w_term_pop),
        .o_data  (w_term_out),
        .o_empty (w_queue_empty)
    );

    dlsn_mac u_mac (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_term_valid (!w_queue_empty),
        .i_term       (w_term_out),
        .o_term_pop   (w_term_pop),
        .o_sum        (w_sum),
        .i_sum_ready  (w_sum_ready)
    );

    dlsn_act #(
        .SIG_DEPTH (SIGMOID_TABLE_DEPTH)
    ) u_act (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_sum          (w_sum),
        .o_sum_ready    (w_sum_ready),
        .i_act_mode     (r_act_mode),
        .i_output_count (r_output_count),
        .o_empty        (empty),
        .i_pop          (pop),
        .o_item         (o_out_item)
    );

endmodule

/* dv/tb_dense_layer_sigmoid_neuron_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dense_layer_sigmoid_neuron_unit
// Self-checking bench for the dense layer neuron unit. A short directed run
// hits saturation in both directions, the sigmoid midpoint, identity mode,
// dropped loads, out-of-range counts and a count lowered mid-neuron. Random
// layer traffic follows over several register settings, with random gaps on
// both queue sides. A bit-exact predictor checks every popped neuron result.
// ----------------------------------------------------------------------------
module tb_dense_layer_sigmoid_neuron_unit;
    import dlsn_pkg::*;

    localparam int STORE_SLOTS   = 64;
    localparam int LUT_DEPTH     = 256;
    localparam int ONE_Q12       = 4096;
    localparam int SETTLE_CYCLES = 120;
    localparam int STUCK_LIMIT   = 5000;
    localparam int PHASE_ITEMS   = 172;
    localparam int NUM_PHASES    = 8;
    localparam int MAX_REPORTS   = 200;

    // keeps its own copy of layer state and the sigmoid table
    class layer_neuron_calc;
        logic signed [15:0] act_store [1:STORE_SLOTS];
        longint unsigned    sig_lut [0:LUT_DEPTH];
        longint             acc;
        int unsigned        term_idx;
        int unsigned        neuron_idx;
        logic [6:0]         n_inputs_reg;
        logic [6:0]         n_outputs_reg;
        logic               identity_mode;
        t_out_item          due_results [$];
        int                 mismatches;
        int                 neurons_checked;
        int                 reports;

        function new();
            longint unsigned e1;
            longint unsigned num;
            longint unsigned a;
            longint unsigned u;
            longint unsigned e;
            longint unsigned s;
            longint unsigned v;
            longint unsigned j;
            int unsigned     i;
            bit              neg;
            for (i = 1; i <= STORE_SLOTS; i++) begin
                act_store[i] = '0;
            end
            acc             = 0;
            term_idx        = 0;
            neuron_idx      = 0;
            n_inputs_reg    = 7'd1;
            n_outputs_reg   = 7'd1;
            identity_mode   = 1'b0;
            mismatches      = 0;
            neurons_checked = 0;
            reports         = 0;
            // q30 exp, integer part by repeated multiply with exp(-1), symmetry below zero
            e1 = exp_neg(Q30_ONE);
            for (i = 0; i <= LUT_DEPTH; i++) begin
                num = 16 * i;
                neg = num < 8 * LUT_DEPTH;
                a   = neg ? 8 * LUT_DEPTH - num : num - 8 * LUT_DEPTH;
                u   = (a << 30) / LUT_DEPTH;
                e   = exp_neg(u & (Q30_ONE - 1));
                for (j = 0; j < (u >> 30); j++) begin
                    e = (e * e1 + (Q30_ONE >> 1)) >> 30;
                end
                s = (64'd1 << 60) / (Q30_ONE + e);
                v = (s * ONE_Q12 + (Q30_ONE >> 1)) >> 30;
                if (v > ONE_Q12) begin
                    v = ONE_Q12;
                end
                sig_lut[i] = neg ? ONE_Q12 - v : v;
            end
        endfunction

        function longint unsigned exp_neg(longint unsigned f);
            longint          sum;
            longint unsigned term;
            int              k;
            sum  = longint'(Q30_ONE);
            term = Q30_ONE;
            for (k = 1; k <= 24; k++) begin
                term = ((term * f) >> 30) / k;
                if (k % 2 == 1) begin
                    sum -= longint'(term);
                end else begin
                    sum += longint'(term);
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            return sum;
        endfunction

        function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_INPUT_COUNT:  n_inputs_reg  = data;
                CFG_OUTPUT_COUNT: n_outputs_reg = data;
                CFG_ACT_MODE:     identity_mode = data[0];
                default:          ;
            endcase
        endfunction

        function void absorb_input(t_in_item it);
            int unsigned n_in;
            int unsigned n_out;
            longint      w;
            longint      x;
            longint      pre;
            longint      pos;
            longint      frac;
            longint      t0;
            longint      t1;
            int          y;
            int          d;
            t_out_item   res;
            if (it.kind == KIND_LOAD) begin
                if (it.act_index >= 1 && it.act_index <= STORE_SLOTS) begin
                    act_store[it.act_index] = it.act_value;
                end
                return;
            end
            n_in  = (n_inputs_reg == 0) ? 1 :
                    (n_inputs_reg > STORE_SLOTS) ? STORE_SLOTS : n_inputs_reg;
            n_out = (n_outputs_reg == 0) ? 1 :
                    (n_outputs_reg > OUT_COUNT_MAX) ? OUT_COUNT_MAX : n_outputs_reg;
            w = it.weight;
            if (term_idx == 0) begin
                // bias term times an implicit 1.0
                acc      = w * ONE_Q12;
                term_idx = 1;
                return;
            end
            x = act_store[term_idx];
            acc += w * x;
            if (term_idx < n_in) begin
                term_idx++;
                return;
            end
            pre = (acc + 2048) >>> 12;
            if (pre > 32767) begin
                pre = 32767;
            end else if (pre < -32768) begin
                pre = -32768;
            end
            if (identity_mode) begin
                y = int'(pre);
                d = ONE_Q12;
            end else begin
                // segment from the top bits of the offset input, linear blend on the rest
                pos  = (pre + 32768) * LUT_DEPTH;
                frac = pos & 64'hFFFF;
                t0   = longint'(sig_lut[pos >>> 16]);
                t1   = longint'(sig_lut[(pos >>> 16) + 1]);
                y    = int'(t0 + (((t1 - t0) * frac + 32768) >>> 16));
                d    = (y * (ONE_Q12 - y) + 2048) / ONE_Q12;
            end
            res.neuron_index   = 7'(neuron_idx + 1);
            res.pre_activation = 16'(pre);
            res.activation     = 16'(y);
            res.derivative     = 13'(d);
            due_results.push_back(res);
            acc      = 0;
            term_idx = 0;
            neuron_idx++;
            if (neuron_idx >= n_out) begin
                neuron_idx = 0;
            end
        endfunction

        function bit field_ok(string fname, longint want, longint got);
            if (want == got) begin
                return 1'b1;
            end
            if (reports < MAX_REPORTS) begin
                $display("%0t ns mismatch on %s: expected %0d, actual %0d",
                         $time, fname, want, got);
            end
            reports++;
            return 1'b0;
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            bit        ok;
            if (due_results.size() == 0) begin
                mismatches++;
                if (reports < MAX_REPORTS) begin
                    $display("%0t ns unexpected result: expected none, actual %0d/%0d/%0d/%0d",
                             $time, got.neuron_index, got.pre_activation,
                             got.activation, got.derivative);
                end
                reports++;
                return;
            end
            want = due_results.pop_front();
            ok   = 1'b1;
            ok  &= field_ok("neuron_index", want.neuron_index, got.neuron_index);
            ok  &= field_ok("pre_activation", want.pre_activation, got.pre_activation);
            ok  &= field_ok("activation", want.activation, got.activation);
            ok  &= field_ok("derivative", want.derivative, got.derivative);
            if (!ok) begin
                mismatches++;
            end
            neurons_checked++;
        endfunction

        function int pending();
            return due_results.size();
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   push;
    t_in_item               in_item;
    logic                   full;
    logic                   empty;
    logic                   pop;
    t_out_item              out_item;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    layer_neuron_calc calc;
    int send_idle_pct  = 0;
    int pop_stall_pct  = 0;
    int stuck_cycles   = 0;
    int items_sent     = 0;
    bit slot_loaded [1:STORE_SLOTS];

    int ph_inputs  [NUM_PHASES] = '{3, 64, 1, 127, 7, 16, 2, 9};
    int ph_outputs [NUM_PHASES] = '{4, 64, 1, 70, 5, 2, 64, 127};
    int ph_modes   [NUM_PHASES] = '{0, 0, 1, 0, 3, 2, 0, 1};

    dense_layer_sigmoid_neuron_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .i_in_item   (in_item),
        .full        (full),
        .empty       (empty),
        .pop         (pop),
        .o_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            calc.check_result(out_item);
        end
        pop <= ($urandom_range(99) >= pop_stall_pct);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("%0t ns watchdog: no transaction for %0d cycles", $time, STUCK_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic logic signed [15:0] rand_q12(input int scale);
        if ($urandom_range(99) < 12) begin
            case ($urandom_range(6))
                0:       return 16'sh8000;
                1:       return 16'sh7FFF;
                2:       return 16'sh0000;
                3:       return -16'sd1;
                4:       return 16'sd1;
                5:       return 16'sd4096;
                default: return -16'sd4096;
            endcase
        end
        case (scale)
            0:       return 16'($urandom);
            1:       return 16'($urandom_range(4095)) - 16'sd2048;
            default: return 16'($urandom_range(511)) - 16'sd256;
        endcase
    endfunction

    task automatic send_item(input t_in_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push    <= 1'b1;
        in_item <= it;
        do begin
            @(posedge i_clk);
        end while (full);
        calc.absorb_input(it);
        if (it.kind == KIND_WEIGHT || (it.act_index >= 1 && it.act_index <= STORE_SLOTS)) begin
            items_sent++;
        end
    endtask

    task automatic send_load(input logic [6:0] slot, input logic signed [15:0] val);
        t_in_item it;
        it.kind      = KIND_LOAD;
        it.act_index = slot;
        it.act_value = val;
        it.weight    = 16'($urandom);
        if (slot >= 1 && slot <= STORE_SLOTS) begin
            slot_loaded[slot] = 1'b1;
        end
        send_item(it);
    endtask

    task automatic send_weight(input logic signed [15:0] w);
        t_in_item it;
        it.kind      = KIND_WEIGHT;
        it.act_index = 7'($urandom);
        it.act_value = 16'($urandom);
        it.weight    = w;
        send_item(it);
    endtask

    // only called once every pending result has been popped
    task automatic program_layer(input logic [6:0] n_in, input logic [6:0] n_out,
                                 input logic [6:0] mode);
        calc.set_reg(CFG_INPUT_COUNT, n_in);
        calc.set_reg(CFG_OUTPUT_COUNT, n_out);
        calc.set_reg(CFG_ACT_MODE, mode);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_INPUT_COUNT;
        cfg_data  <= n_in;
        @(posedge i_clk);
        cfg_index <= CFG_OUTPUT_COUNT;
        cfg_data  <= n_out;
        @(posedge i_clk);
        cfg_index <= CFG_ACT_MODE;
        cfg_data  <= mode;
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // drain results, then give a partial neuron time to leave the pipeline
    task automatic settle_idle();
        push <= 1'b0;
        while (calc.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        int       ph;
        int       k;
        int       n_eff;
        int       scale;
        int       roll;
        int       start_items;
        bit       paused;
        calc = new();
        for (k = 1; k <= STORE_SLOTS; k++) begin
            slot_loaded[k] = 1'b0;
        end
        i_rst_n   <= 1'b0;
        push      <= 1'b0;
        pop       <= 1'b0;
        in_item   <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_INPUT_COUNT;
        cfg_data  <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        program_layer(7'd2, 7'd3, 7'd0);
        send_load(7'd1, 16'sh7FFF);
        send_load(7'd2, 16'sh8000);
        // loads outside the store are dropped
        send_load(7'd0, 16'sh1234);
        send_load(7'd65, 16'sh0777);
        send_load(7'd127, -16'sd1);
        // saturate high, saturate low, then the sigmoid midpoint
        send_weight(16'sh7FFF);
        send_weight(16'sh7FFF);
        send_weight(16'sh8000);
        send_weight(16'sh8000);
        send_weight(16'sh8000);
        send_weight(16'sh7FFF);
        send_weight(16'sh0000);
        send_weight(16'sh0000);
        send_weight(16'sh0000);
        settle_idle();
        program_layer(7'd2, 7'd3, 7'd1);
        send_weight(16'sd4096);
        send_weight(16'sd1);
        send_weight(-16'sd1);
        settle_idle();
        // lower the count while a neuron is half done
        program_layer(7'd5, 7'd3, 7'd1);
        send_load(7'd3, 16'sd4096);
        send_load(7'd4, -16'sd4096);
        send_load(7'd5, 16'sd100);
        send_weight(16'sd2048);
        send_weight(16'sd4096);
        send_weight(-16'sd4096);
        send_weight(16'sd8192);
        settle_idle();
        program_layer(7'd2, 7'd3, 7'd1);
        send_weight(16'sd4096);
        settle_idle();
        // zero counts act as one, mode bit 1 ignored
        program_layer(7'd0, 7'd0, 7'd2);
        send_weight(-16'sd4096);
        send_weight(16'sd4096);
        settle_idle();

        for (ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph % 4)
                0: begin
                    send_idle_pct = 0;
                    pop_stall_pct = 0;
                end
                1: begin
                    send_idle_pct = 61;
                    pop_stall_pct = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    pop_stall_pct = 61;
                end
                default: begin
                    send_idle_pct = 14;
                    pop_stall_pct = 14;
                end
            endcase
            program_layer(7'(ph_inputs[ph]), 7'(ph_outputs[ph]), 7'(ph_modes[ph]));
            n_eff = (ph_inputs[ph] < 1) ? 1 :
                    (ph_inputs[ph] > STORE_SLOTS) ? STORE_SLOTS : ph_inputs[ph];
            start_items = items_sent;
            paused      = 1'b0;
            while (items_sent - start_items < PHASE_ITEMS) begin
                if (!paused && items_sent - start_items >= PHASE_ITEMS / 2) begin
                    // hold the sender until every result has been popped
                    push <= 1'b0;
                    do begin
                        @(posedge i_clk);
                    end while (calc.pending() != 0);
                    paused = 1'b1;
                end
                roll = $urandom_range(99);
                if (roll < 6) begin
                    send_load(($urandom_range(1) == 0) ? 7'd0 : 7'($urandom_range(127, 65)),
                              rand_q12(0));
                end else if (roll < 16) begin
                    send_load(7'($urandom_range(STORE_SLOTS, 1)), rand_q12($urandom_range(2)));
                end else begin
                    scale = $urandom_range(2);
                    for (k = 1; k <= n_eff; k++) begin
                        if (!slot_loaded[k] || $urandom_range(99) < 10) begin
                            send_load(7'(k), rand_q12($urandom_range(2)));
                        end
                    end
                    send_weight(rand_q12(scale));
                    for (k = 1; k <= n_eff; k++) begin
                        // stray loads inside a neuron, some to slots that do not exist
                        if ($urandom_range(99) < 5) begin
                            send_load(7'($urandom_range(127)), rand_q12(0));
                        end
                        send_weight(rand_q12(scale));
                    end
                end
            end
            settle_idle();
        end

        $display("coverage: %0d transactions over %0d register settings, %0d neurons checked",
                 items_sent, NUM_PHASES + 5, calc.neurons_checked);
        $display("coverage: sigmoid and identity, saturation both ways, clamped counts, stalls");
        if (calc.mismatches == 0 && calc.pending() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
